@@ design/idm_pkg.sv @@
// ----------------------------------------------------------------------------
// idm_pkg: shared definitions for the integer divide/modulo block
// Word width, operation code bits and the control/status bundle between the
// sequencer and the shift-subtract divider.
// ----------------------------------------------------------------------------
package idm_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int CNT_W      = $clog2(DATA_WIDTH);
  localparam int OP_W       = 2;

  // operation code bits: bit 0 selects signed, bit 1 selects remainder
  localparam int OP_SIGNED_BIT = 0;
  localparam int OP_REM_BIT    = 1;

  typedef logic [DATA_WIDTH-1:0] word_t;
  typedef logic [CNT_W-1:0]      count_t;

  // sequencer to divider
  typedef struct packed {
    logic start;
  } div_ctrl_t;

  // divider to sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

@@ design/idm_divider.sv @@
// ----------------------------------------------------------------------------
// idm_divider: radix-2 restoring shift-subtract divider
// Unsigned magnitudes in, one quotient bit per cycle shifted into the
// dividend register, partial remainder kept beside it.
// ----------------------------------------------------------------------------
module idm_divider (
  input  logic               clk,
  input  logic               rst,
  input  idm_pkg::div_ctrl_t ctrl,
  input  idm_pkg::word_t     num,
  input  idm_pkg::word_t     den_in,
  output idm_pkg::word_t     quotient,
  output idm_pkg::word_t     remainder,
  output idm_pkg::div_stat_t stat
);
  import idm_pkg::*;

  logic                busy;
  logic                done;
  count_t              cnt;
  word_t               rem;
  word_t               quo;
  word_t               den;
  logic [DATA_WIDTH:0] partial;
  logic [DATA_WIDTH:0] diff;

  // trial subtract of the divisor from the shifted partial remainder
  always_comb begin
    partial = {rem, quo[DATA_WIDTH-1]};
    diff    = partial - {1'b0, den};
  end

  // control: count down one step per quotient bit
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctrl.start) begin
        busy <= 1'b1;
        cnt  <= count_t'(DATA_WIDTH - 1);
      end else if (busy) begin
        cnt <= cnt - count_t'(1);
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath: restore on borrow, else keep the difference
  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      rem <= '0;
      quo <= num;
      den <= den_in;
    end else if (busy) begin
      if (diff[DATA_WIDTH]) begin
        rem <= partial[DATA_WIDTH-1:0];
        quo <= {quo[DATA_WIDTH-2:0], 1'b0};
      end else begin
        rem <= diff[DATA_WIDTH-1:0];
        quo <= {quo[DATA_WIDTH-2:0], 1'b1};
      end
    end
  end

  assign quotient  = quo;
  assign remainder = rem;
  assign stat      = '{busy: busy, done: done};

  // partial remainder never reaches the divisor during the loop
  a_rem_below_den: assert property (@(posedge clk) disable iff (rst)
    busy && den != '0 |-> rem < den)
    else $error("partial remainder not below divisor");

endmodule

@@ design/integer_divide_modulo.sv @@
// ----------------------------------------------------------------------------
// integer_divide_modulo: 32-bit integer divide and remainder
// Each transaction runs IDLE, PREP, DIV and FIX; a zero divisor skips DIV.
// One transaction at a time: the 32-step shift-subtract loop yields one
// quotient bit per cycle, and input is taken again once FIX loads the result.
// A finished result waits in the output register while the next input is taken.
// Reset (rst, synchronous) empties the output register and returns to idle.
// ----------------------------------------------------------------------------
module integer_divide_modulo (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [idm_pkg::OP_W-1:0]  operation,
  input  idm_pkg::word_t            dividend_word,
  input  idm_pkg::word_t            divisor_word,
  output logic                      out_valid,
  input  logic                      out_ready,
  output idm_pkg::word_t            result_word,
  output logic                      divide_by_zero
);
  import idm_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_PREP = 4'b0010,
    S_DIV  = 4'b0100,
    S_FIX  = 4'b1000
  } state_t;

  state_t          state;
  state_t          state_next;
  logic [OP_W-1:0] op_q;
  word_t           a_q;
  word_t           b_q;
  logic            neg_a;
  logic            neg_b;
  logic            zero_q;
  logic            a_neg_now;
  logic            b_neg_now;
  word_t           mag_a;
  word_t           mag_b;
  word_t           quotient;
  word_t           remainder;
  div_ctrl_t       core_ctrl;
  div_stat_t       core_stat;
  word_t           pick;
  logic            flip;
  word_t           result_next;
  logic            load_out;

  assign in_ready = (state == S_IDLE);

  // magnitudes of the signed operands
  always_comb begin
    a_neg_now = op_q[OP_SIGNED_BIT] & a_q[DATA_WIDTH-1];
    b_neg_now = op_q[OP_SIGNED_BIT] & b_q[DATA_WIDTH-1];
    mag_a     = a_neg_now ? (~a_q + word_t'(1)) : a_q;
    mag_b     = b_neg_now ? (~b_q + word_t'(1)) : b_q;
  end

  assign core_ctrl.start = (state == S_PREP) && (b_q != '0);

  idm_divider u_divider (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (core_ctrl),
    .num       (mag_a),
    .den_in    (mag_b),
    .quotient  (quotient),
    .remainder (remainder),
    .stat      (core_stat)
  );

  // sign fix-up and divide-by-zero fallback
  always_comb begin
    pick = op_q[OP_REM_BIT] ? remainder : quotient;
    flip = op_q[OP_REM_BIT] ? neg_a : (neg_a ^ neg_b);
    if (zero_q) begin
      result_next = op_q[OP_REM_BIT] ? a_q : '1;
    end else begin
      result_next = flip ? (~pick + word_t'(1)) : pick;
    end
  end

  assign load_out = (state == S_FIX) && (!out_valid || out_ready);

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (in_valid) state_next = S_PREP;
      S_PREP: state_next = (b_q == '0) ? S_FIX : S_DIV;
      S_DIV:  if (core_stat.done) state_next = S_FIX;
      S_FIX:  if (load_out) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // capture the transaction and the operand signs
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_q <= operation;
      a_q  <= dividend_word;
      b_q  <= divisor_word;
    end
    if (state == S_PREP) begin
      neg_a  <= a_neg_now;
      neg_b  <= b_neg_now;
      zero_q <= (b_q == '0);
    end
  end

  // output register: hold until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      result_word    <= result_next;
      divide_by_zero <= zero_q;
    end
  end

  // divider runs only while the sequencer waits on it
  a_busy_in_div: assert property (@(posedge clk) disable iff (rst)
    core_stat.busy |-> state == S_DIV)
    else $error("divider busy outside divide state");

  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    core_stat.done |-> state == S_DIV)
    else $error("divider done outside divide state");

  a_zero_flag: assert property (@(posedge clk) disable iff (rst)
    load_out |=> out_valid && (divide_by_zero == $past(zero_q)))
    else $error("output flag does not follow divisor check");

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking testbench for integer_divide_modulo
// Drives a table of directed divide/remainder transactions, then a long run of
// random operand shapes covering zero divisors, the most negative dividend over
// minus one, small and full-range words. Each result is checked against its
// hand-read table value or an in-bench divide model. Both handshake sides idle
// at random, and one long output hold-off backs the block up into its input.
// ----------------------------------------------------------------------------
module tb;

  import idm_pkg::*;

  localparam int RANDOM_ITEMS = 725;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 60;
  localparam int HOLD_CYCLES  = 600;
  localparam int HOLD_AT_ITEM = 420;
  localparam int QUIET_FIRST  = 150;
  localparam int QUIET_LAST   = 320;

  typedef enum logic [OP_W-1:0] {
    OP_UDIV = 2'd0,
    OP_SDIV = 2'd1,
    OP_UREM = 2'd2,
    OP_SREM = 2'd3
  } op_t;

  typedef struct packed {
    word_t word;
    logic  dbz;
  } div_result_t;

  typedef struct packed {
    op_t   op;
    word_t dividend;
    word_t divisor;
    logic  typed;
    word_t word;
    logic  dbz;
  } stim_row_t;

  localparam word_t ALL_ONES = '1;
  localparam word_t MOST_NEG = {1'b1, {(DATA_WIDTH-1){1'b0}}};
  localparam word_t MOST_POS = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam word_t ZERO     = '0;
  localparam word_t ONE      = 1;

  logic  clk;
  logic  rst;
  logic  in_valid;
  logic  in_ready;
  logic  [OP_W-1:0] operation;
  word_t dividend_word;
  word_t divisor_word;
  logic  out_valid;
  logic  out_ready;
  word_t result_word;
  logic  divide_by_zero;

  div_result_t pending_results[$];
  int          error_cnt;
  int          items_sent;
  int          results_seen;
  int          cycle_cnt;
  int          op_cnt[4];
  int          dbz_cnt;
  int          wrap_cnt;

  // directed transactions; typed rows carry a hand-read result
  stim_row_t dir_rows [0:24] = '{
    '{OP_UDIV, 32'd100,       32'd7,         1'b0, ZERO,        1'b0},
    '{OP_UDIV, ALL_ONES,      ONE,           1'b1, ALL_ONES,    1'b0},
    '{OP_UDIV, ZERO,          ONE,           1'b1, ZERO,        1'b0},
    '{OP_UDIV, 32'd5,         ZERO,          1'b1, ALL_ONES,    1'b1},
    '{OP_SDIV, 32'd5,         ZERO,          1'b1, ALL_ONES,    1'b1},
    '{OP_UREM, 32'd12345,     ZERO,          1'b1, 32'd12345,   1'b1},
    '{OP_SREM, MOST_NEG,      ZERO,          1'b1, MOST_NEG,    1'b1},
    '{OP_SDIV, MOST_NEG,      ALL_ONES,      1'b1, MOST_NEG,    1'b0},
    '{OP_SREM, MOST_NEG,      ALL_ONES,      1'b1, ZERO,        1'b0},
    '{OP_UDIV, 32'd3,         32'd10,        1'b1, ZERO,        1'b0},
    '{OP_UREM, 32'd3,         32'd10,        1'b1, 32'd3,       1'b0},
    '{OP_UDIV, ALL_ONES,      ALL_ONES,      1'b1, ONE,         1'b0},
    '{OP_UREM, ALL_ONES,      ALL_ONES,      1'b1, ZERO,        1'b0},
    '{OP_SDIV, -32'sd7,       32'd2,         1'b0, ZERO,        1'b0},
    '{OP_SREM, -32'sd7,       32'd2,         1'b0, ZERO,        1'b0},
    '{OP_SDIV, 32'd7,         -32'sd2,       1'b0, ZERO,        1'b0},
    '{OP_SREM, 32'd7,         -32'sd2,       1'b0, ZERO,        1'b0},
    '{OP_SDIV, -32'sd7,       -32'sd2,       1'b0, ZERO,        1'b0},
    '{OP_UDIV, MOST_NEG,      ONE,           1'b1, MOST_NEG,    1'b0},
    '{OP_UREM, ALL_ONES,      MOST_NEG,      1'b0, ZERO,        1'b0},
    '{OP_SDIV, MOST_POS,      ONE,           1'b1, MOST_POS,    1'b0},
    '{OP_SDIV, MOST_NEG,      ONE,           1'b1, MOST_NEG,    1'b0},
    '{OP_UDIV, ONE,           ALL_ONES,      1'b1, ZERO,        1'b0},
    '{OP_SREM, ZERO,          ZERO,          1'b1, ZERO,        1'b1},
    '{OP_UDIV, 32'hdeadbeef,  32'h00000010,  1'b0, ZERO,        1'b0}
  };

  integer_divide_modulo i_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .operation      (operation),
    .dividend_word  (dividend_word),
    .divisor_word   (divisor_word),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .result_word    (result_word),
    .divide_by_zero (divide_by_zero)
  );

  // quotient or remainder of one transaction, signs fixed after a magnitude divide
  function automatic div_result_t divide_model(op_t op, word_t num, word_t den);
    logic        is_signed;
    logic        want_rem;
    logic        num_neg;
    logic        den_neg;
    word_t       num_mag;
    word_t       den_mag;
    word_t       quo;
    word_t       rem;
    div_result_t res;
    is_signed = op[OP_SIGNED_BIT];
    want_rem  = op[OP_REM_BIT];
    num_neg   = is_signed && num[DATA_WIDTH-1];
    den_neg   = is_signed && den[DATA_WIDTH-1];
    if (den == ZERO) begin
      res.word = want_rem ? num : ALL_ONES;
      res.dbz  = 1'b1;
      return res;
    end
    num_mag = num_neg ? ~num + ONE : num;
    den_mag = den_neg ? ~den + ONE : den;
    quo = num_mag / den_mag;
    rem = num_mag % den_mag;
    if (want_rem) begin
      res.word = num_neg ? ~rem + ONE : rem;
    end else begin
      res.word = (num_neg != den_neg) ? ~quo + ONE : quo;
    end
    res.dbz = 1'b0;
    return res;
  endfunction

  // random word of a random shape: full range, small, extreme, power of two, shifted
  function automatic word_t pick_word();
    word_t w;
    w = $urandom;
    case ($urandom_range(9))
      4: w = $urandom_range(15);
      5: begin
        case ($urandom_range(4))
          0: w = ZERO;
          1: w = ONE;
          2: w = ALL_ONES;
          3: w = MOST_NEG;
          default: w = MOST_POS;
        endcase
      end
      6: w = (ONE << $urandom_range(DATA_WIDTH-1)) - $urandom_range(1);
      7: w = w >> $urandom_range(DATA_WIDTH-1);
      8: w = ~word_t'($urandom_range(15));
      default: ;
    endcase
    return w;
  endfunction

  // offer one transaction, hold it until accepted, then queue its result
  task automatic send_item(op_t op, word_t num, word_t den, logic typed,
                           word_t typed_word, logic typed_dbz);
    div_result_t exp_res;
    logic        quiet;
    quiet = items_sent >= QUIET_FIRST && items_sent <= QUIET_LAST;
    if (!quiet && $urandom_range(99) < 7) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    operation     <= op;
    dividend_word <= num;
    divisor_word  <= den;
    do @(posedge clk); while (!in_ready);
    if (typed) begin
      exp_res.word = typed_word;
      exp_res.dbz  = typed_dbz;
    end else begin
      exp_res = divide_model(op, num, den);
    end
    pending_results.push_back(exp_res);
    items_sent++;
    op_cnt[op]++;
    if (den == ZERO) dbz_cnt++;
    if (op[OP_SIGNED_BIT] && num == MOST_NEG && den == ALL_ONES) wrap_cnt++;
  endtask

  // free-running clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // abort on a hung run
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still pending", cycle_cnt,
               pending_results.size());
      $display("status: fail");
      $finish;
    end
  end

  // output side: random idling, a quiet stretch, and one long hold-off
  initial begin : receiver
    int  stall_left;
    logic hold_done;
    stall_left = 0;
    hold_done  = 1'b0;
    out_ready  = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (!hold_done && items_sent >= HOLD_AT_ITEM) begin
        hold_done  = 1'b1;
        stall_left = HOLD_CYCLES - 1;
        out_ready  <= 1'b0;
      end else if (items_sent >= QUIET_FIRST && items_sent <= QUIET_LAST) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= 7);
      end
    end
  end

  // compare each accepted result with the oldest pending one
  always @(posedge clk) begin
    div_result_t exp_res;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        error_cnt++;
        $display("%0t: unexpected result result_word %h divide_by_zero %b", $time,
                 result_word, divide_by_zero);
      end else begin
        exp_res = pending_results.pop_front();
        if (result_word !== exp_res.word) begin
          error_cnt++;
          $display("%0t: result_word mismatch expected %h actual %h", $time,
                   exp_res.word, result_word);
        end
        if (divide_by_zero !== exp_res.dbz) begin
          error_cnt++;
          $display("%0t: divide_by_zero mismatch expected %b actual %b", $time,
                   exp_res.dbz, divide_by_zero);
        end
      end
    end
  end

  // reset, stimulus, drain and verdict
  initial begin : stimulus
    op_t   op;
    word_t num;
    word_t den;
    rst           = 1'b1;
    in_valid      = 1'b0;
    operation     = '0;
    dividend_word = '0;
    divisor_word  = '0;
    error_cnt     = 0;
    items_sent    = 0;
    results_seen  = 0;
    cycle_cnt     = 0;
    dbz_cnt       = 0;
    wrap_cnt      = 0;
    foreach (op_cnt[i]) op_cnt[i] = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // walk the directed table
    foreach (dir_rows[i]) begin
      send_item(dir_rows[i].op, dir_rows[i].dividend, dir_rows[i].divisor,
                dir_rows[i].typed, dir_rows[i].word, dir_rows[i].dbz);
    end

    // random operands with occasional zero divisors and the wrapping case
    repeat (RANDOM_ITEMS) begin
      op  = op_t'($urandom_range(3));
      num = pick_word();
      den = pick_word();
      case ($urandom_range(99))
        0, 1, 2, 3, 4: den = ZERO;
        5, 6, 7: begin
          num = MOST_NEG;
          den = ALL_ONES;
        end
        default: ;
      endcase
      send_item(op, num, den, 1'b0, ZERO, 1'b0);
    end
    in_valid <= 1'b0;

    // drain outstanding results, then watch for stray ones
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("checked %0d results: %0d udiv, %0d sdiv, %0d urem, %0d srem", results_seen,
             op_cnt[OP_UDIV], op_cnt[OP_SDIV], op_cnt[OP_UREM], op_cnt[OP_SREM]);
    $display("%0d zero divisors, %0d most-negative by minus one, %0d errors", dbz_cnt,
             wrap_cnt, error_cnt);
    if (error_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ integer_divide_modulo.f @@
design/idm_pkg.sv
design/idm_divider.sv
design/integer_divide_modulo.sv
sim/tb.sv
